// File: rtl/mrrs_pkg.sv
// ---------------------------------------------------------------------------
// mrrs_pkg
// Shared codes and payload types of the motion record/replay sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

package mrrs_pkg;

    localparam int ACTION_W  = 3;
    localparam int DIR_W     = 2;
    localparam int DRIVE_W   = 3;
    localparam int MODE_W    = 2;
    localparam int ENTRIES_W = 7;

    typedef logic [ACTION_W-1:0]  t_action;
    typedef logic [DIR_W-1:0]     t_dir;
    typedef logic [DRIVE_W-1:0]   t_drive;
    typedef logic [MODE_W-1:0]    t_mode;
    typedef logic [ENTRIES_W-1:0] t_entries;

    localparam t_action ACT_TICK       = 3'd0;
    localparam t_action ACT_BEGIN_REC  = 3'd1;
    localparam t_action ACT_RECORD     = 3'd2;
    localparam t_action ACT_STOP_MARK  = 3'd3;
    localparam t_action ACT_BEGIN_PLAY = 3'd4;

    localparam t_mode MODE_IDLE = 2'd0;
    localparam t_mode MODE_REC  = 2'd1;
    localparam t_mode MODE_PLAY = 2'd2;

    localparam t_drive DRIVE_STOP = 3'd4;

endpackage

`default_nettype wire

// File: rtl/mrrs_cmd_if.sv
// ---------------------------------------------------------------------------
// mrrs_cmd_if
// Command channel: action code and direction, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface mrrs_cmd_if;
    import mrrs_pkg::*;

    logic    valid;
    logic    ready;
    t_action action;
    t_dir    direction;

    modport source (output valid, output action, output direction, input ready);
    modport sink   (input valid, input action, input direction, output ready);
endinterface

`default_nettype wire

// File: rtl/mrrs_res_if.sv
// ---------------------------------------------------------------------------
// mrrs_res_if
// Result channel: drive, mode and store status, valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface mrrs_res_if;
    import mrrs_pkg::*;

    logic     valid;
    logic     ready;
    t_drive   drive;
    t_mode    mode_now;
    t_entries stored_entries;
    logic     replay_done;
    logic     dropped;

    modport source (output valid, output drive, output mode_now, output stored_entries,
                    output replay_done, output dropped, input ready);
    modport sink   (input valid, input drive, input mode_now, input stored_entries,
                    input replay_done, input dropped, output ready);
endinterface

`default_nettype wire

// File: rtl/mrrs_store.sv
// ---------------------------------------------------------------------------
// mrrs_store
// Direction and duration memories with one write port each and registered
// read ports for the current and the following entry.
// ---------------------------------------------------------------------------
`default_nettype none

module mrrs_store #(
    parameter int STORE_DEPTH = 64,
    parameter int TICK_BITS   = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_dir_we,
    input  wire logic                           i_dur_we,
    input  wire logic [$clog2(STORE_DEPTH)-1:0] i_waddr,
    input  wire mrrs_pkg::t_dir                 i_dir_wdata,
    input  wire logic [TICK_BITS-1:0]           i_dur_wdata,
    input  wire logic [$clog2(STORE_DEPTH)-1:0] i_cur_addr,
    input  wire logic [$clog2(STORE_DEPTH)-1:0] i_nxt_addr,
    output      logic [TICK_BITS-1:0]           o_cur_dur,
    output      mrrs_pkg::t_dir                 o_nxt_dir
);
    import mrrs_pkg::*;

    t_dir                 r_dir_mem [STORE_DEPTH];
    logic [TICK_BITS-1:0] r_dur_mem [STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_dir_we) begin
            r_dir_mem[i_waddr] <= i_dir_wdata;
        end
        o_nxt_dir <= r_dir_mem[i_nxt_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_dur_we) begin
            r_dur_mem[i_waddr] <= i_dur_wdata;
        end
        o_cur_dur <= r_dur_mem[i_cur_addr];
    end

endmodule

`default_nettype wire

// File: rtl/motion_record_replay_sequencer.sv
// ---------------------------------------------------------------------------
// motion_record_replay_sequencer
// Records direction commands with their tick durations and replays them.
// ---------------------------------------------------------------------------
// Takes one command per clock unless a stalled result holds the result
// register, and answers each with one result through that register in the
// cycle after it is taken. Each command is finished in the cycle it is
// taken. Replay reads the store through registered ports that are always
// addressed at the entry being played and the one after it, so the data
// is ready before the next tick arrives. The store needs no clearing
// after reset: only entries below the entry count are ever read.
`default_nettype none

module motion_record_replay_sequencer #(
    parameter int STORE_DEPTH = 64,
    parameter int TICK_BITS   = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mrrs_cmd_if.sink   i_cmd,
    mrrs_res_if.source o_res
);
    import mrrs_pkg::*;

    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = $clog2(STORE_DEPTH + 1);
    localparam logic [CW-1:0]        DEPTH_C  = CW'(STORE_DEPTH);
    localparam logic [AW-1:0]        LAST_IDX = AW'(STORE_DEPTH - 1);
    localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

    logic [CW-1:0]        r_entry_count, n_entry_count;
    logic [AW-1:0]        r_play_index, n_play_index;
    logic [TICK_BITS-1:0] r_tick, n_tick;
    t_mode                r_mode, n_mode;
    t_drive               r_drive, n_drive;
    t_dir                 r_dir0, n_dir0;

    logic     r_out_valid;
    t_drive   r_out_drive;
    t_mode    r_out_mode;
    t_entries r_out_entries;
    logic     r_out_done;
    logic     r_out_drop;

    logic                 w_accept;
    logic                 w_done;
    logic                 w_drop;
    logic                 w_dir_we;
    logic                 w_dur_we;
    logic [AW-1:0]        w_waddr;
    logic [TICK_BITS-1:0] w_dur_wdata;
    logic [TICK_BITS-1:0] w_tick_up;
    logic [CW-1:0]        w_play_inc;
    logic [CW-1:0]        w_last_entry;
    logic [AW-1:0]        w_nxt_addr;
    logic [TICK_BITS-1:0] w_cur_dur;
    t_dir                 w_nxt_dir;

    assign i_cmd.ready = !r_out_valid || o_res.ready;
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    assign w_tick_up    = (r_tick == TICK_MAX) ? r_tick : r_tick + 1'b1;
    assign w_play_inc   = CW'(r_play_index) + 1'b1;
    assign w_last_entry = r_entry_count - 1'b1;

    always_comb begin
        n_entry_count = r_entry_count;
        n_play_index  = r_play_index;
        n_tick        = r_tick;
        n_mode        = r_mode;
        n_drive       = r_drive;
        n_dir0        = r_dir0;
        w_done        = 1'b0;
        w_drop        = 1'b0;
        w_dir_we      = 1'b0;
        w_dur_we      = 1'b0;
        w_waddr       = r_entry_count[AW-1:0];
        w_dur_wdata   = '0;

        if (w_accept) begin
            if (r_mode == MODE_PLAY) begin
                if (i_cmd.action == ACT_TICK) begin
                    if (r_tick >= w_cur_dur) begin
                        n_tick = '0;
                        if (w_play_inc >= r_entry_count) begin
                            n_drive       = DRIVE_STOP;
                            n_mode        = MODE_IDLE;
                            n_entry_count = '0;
                            n_play_index  = '0;
                            w_done        = 1'b1;
                        end else begin
                            n_play_index = r_play_index + 1'b1;
                            n_drive      = {1'b0, w_nxt_dir};
                        end
                    end else begin
                        n_tick = w_tick_up;
                    end
                end
            end else begin
                case (i_cmd.action)
                    ACT_TICK: begin
                        n_tick = w_tick_up;
                    end
                    ACT_BEGIN_REC: begin
                        n_mode = MODE_REC;
                        n_tick = '0;
                    end
                    ACT_RECORD: begin
                        if (r_mode == MODE_REC) begin
                            if (r_entry_count < DEPTH_C) begin
                                w_dir_we      = 1'b1;
                                w_dur_we      = 1'b1;
                                n_entry_count = r_entry_count + 1'b1;
                                n_tick        = '0;
                                if (r_entry_count == '0) begin
                                    n_dir0 = i_cmd.direction;
                                end
                            end else begin
                                w_drop = 1'b1;
                            end
                        end
                    end
                    ACT_STOP_MARK: begin
                        if (r_mode == MODE_REC && r_entry_count != '0) begin
                            w_dur_we    = 1'b1;
                            w_waddr     = w_last_entry[AW-1:0];
                            w_dur_wdata = r_tick;
                        end
                    end
                    ACT_BEGIN_PLAY: begin
                        if (r_entry_count == '0) begin
                            n_drive      = DRIVE_STOP;
                            n_mode       = MODE_IDLE;
                            n_play_index = '0;
                            n_tick       = '0;
                            w_done       = 1'b1;
                        end else begin
                            n_mode       = MODE_PLAY;
                            n_play_index = '0;
                            n_tick       = '0;
                            n_drive      = {1'b0, r_dir0};
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // read ports follow the entry that will be current after this edge
    assign w_nxt_addr = (n_play_index == LAST_IDX) ? '0 : n_play_index + 1'b1;

    mrrs_store #(
        .STORE_DEPTH (STORE_DEPTH),
        .TICK_BITS   (TICK_BITS)
    ) u_store (
        .i_clk       (i_clk),
        .i_dir_we    (w_dir_we),
        .i_dur_we    (w_dur_we),
        .i_waddr     (w_waddr),
        .i_dir_wdata (i_cmd.direction),
        .i_dur_wdata (w_dur_wdata),
        .i_cur_addr  (n_play_index),
        .i_nxt_addr  (w_nxt_addr),
        .o_cur_dur   (w_cur_dur),
        .o_nxt_dir   (w_nxt_dir)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_play_index  <= '0;
            r_tick        <= '0;
            r_mode        <= MODE_IDLE;
            r_drive       <= DRIVE_STOP;
            r_dir0        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_entry_count <= n_entry_count;
            r_play_index  <= n_play_index;
            r_tick        <= n_tick;
            r_mode        <= n_mode;
            r_drive       <= n_drive;
            r_dir0        <= n_dir0;
            if (i_cmd.ready) begin
                r_out_valid <= i_cmd.valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_drive   <= n_drive;
            r_out_mode    <= n_mode;
            r_out_entries <= t_entries'(n_entry_count);
            r_out_done    <= w_done;
            r_out_drop    <= w_drop;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.drive          = r_out_drive;
    assign o_res.mode_now       = r_out_mode;
    assign o_res.stored_entries = r_out_entries;
    assign o_res.replay_done    = r_out_done;
    assign o_res.dropped        = r_out_drop;

`ifndef ASSERT_OFF
    a_stop_outside_play: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode != MODE_PLAY) |-> (r_drive == DRIVE_STOP))
        else $error("drive not stopped outside replay");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_entry_count <= DEPTH_C)
        else $error("entry count beyond store depth");

    a_play_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_PLAY) |-> (CW'(r_play_index) < r_entry_count))
        else $error("replay index beyond recorded entries");

    a_done_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_done) |=> (r_mode == MODE_IDLE && r_entry_count == '0
                                  && r_out_done && r_out_drive == DRIVE_STOP))
        else $error("replay end did not empty the store");

    a_full_drops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_mode == MODE_REC && i_cmd.action == ACT_RECORD
         && r_entry_count == DEPTH_C) |=> (r_out_drop && r_entry_count == DEPTH_C))
        else $error("direction into full store not flagged");
`endif

endmodule

`default_nettype wire

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench of the motion record/replay sequencer. A short table of commands
// covers every action and the corner cases, then random record/replay
// sessions run with and without random sender idling and receiver stalls.
// Each result is compared field by field with the tb model or its table row.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mrrs_pkg::*;

    localparam int DEPTH       = 64;
    localparam int TBITS       = 16;
    localparam int TICK_MAX    = (1 << TBITS) - 1;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int RANDOM_CMDS = 300;

    localparam t_dir DIR_FWD   = 2'd0;
    localparam t_dir DIR_LEFT  = 2'd1;
    localparam t_dir DIR_BACK  = 2'd2;
    localparam t_dir DIR_RIGHT = 2'd3;

    localparam t_drive DRIVE_FWD = 3'd0;

    localparam t_action ACT_SPARE_5 = 3'd5;
    localparam t_action ACT_SPARE_6 = 3'd6;
    localparam t_action ACT_SPARE_7 = 3'd7;

    typedef struct packed {
        t_drive   drive;
        t_mode    mode_now;
        t_entries entries;
        logic     done;
        logic     dropped;
    } t_status;

    typedef struct packed {
        t_action action;
        t_dir    dir;
        logic    fixed;
        t_status want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mrrs_cmd_if cmd_ch ();
    mrrs_res_if res_ch ();

    motion_record_replay_sequencer #(
        .STORE_DEPTH (DEPTH),
        .TICK_BITS   (TBITS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_ch),
        .o_res   (res_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // model of the sequencer
    t_dir             path_dir   [DEPTH];
    logic [TBITS-1:0] path_ticks [DEPTH];
    int               n_entries;
    int               play_pos;
    logic [TBITS-1:0] tick_ctr;
    t_mode            cur_mode;
    t_drive           cur_drive;

    t_status status_q [$];
    int      mismatches  = 0;
    int      cmds_sent   = 0;
    int      cycle_count = 0;
    int      tx_idle_pct = 0;
    int      rx_stall_pct = 0;

    // directed commands; rows with fixed set carry the status typed in
    t_row directed_rows [0:24] = '{
        '{ACT_TICK,       DIR_FWD,   1'b1, '{DRIVE_STOP, MODE_IDLE, 7'd0, 1'b0, 1'b0}},
        '{ACT_BEGIN_PLAY, DIR_FWD,   1'b1, '{DRIVE_STOP, MODE_IDLE, 7'd0, 1'b1, 1'b0}},
        '{ACT_RECORD,     DIR_RIGHT, 1'b1, '{DRIVE_STOP, MODE_IDLE, 7'd0, 1'b0, 1'b0}},
        '{ACT_STOP_MARK,  DIR_FWD,   1'b1, '{DRIVE_STOP, MODE_IDLE, 7'd0, 1'b0, 1'b0}},
        '{ACT_SPARE_5,    DIR_LEFT,  1'b1, '{DRIVE_STOP, MODE_IDLE, 7'd0, 1'b0, 1'b0}},
        '{ACT_SPARE_6,    DIR_BACK,  1'b1, '{DRIVE_STOP, MODE_IDLE, 7'd0, 1'b0, 1'b0}},
        '{ACT_SPARE_7,    DIR_RIGHT, 1'b1, '{DRIVE_STOP, MODE_IDLE, 7'd0, 1'b0, 1'b0}},
        '{ACT_BEGIN_REC,  DIR_FWD,   1'b1, '{DRIVE_STOP, MODE_REC,  7'd0, 1'b0, 1'b0}},
        '{ACT_STOP_MARK,  DIR_FWD,   1'b1, '{DRIVE_STOP, MODE_REC,  7'd0, 1'b0, 1'b0}},
        '{ACT_RECORD,     DIR_FWD,   1'b1, '{DRIVE_STOP, MODE_REC,  7'd1, 1'b0, 1'b0}},
        '{ACT_TICK,       DIR_RIGHT, 1'b0, '0},
        '{ACT_STOP_MARK,  DIR_FWD,   1'b0, '0},
        '{ACT_TICK,       DIR_FWD,   1'b0, '0},
        '{ACT_STOP_MARK,  DIR_FWD,   1'b0, '0},
        '{ACT_RECORD,     DIR_LEFT,  1'b0, '0},
        '{ACT_BEGIN_REC,  DIR_FWD,   1'b0, '0},
        '{ACT_RECORD,     DIR_BACK,  1'b0, '0},
        '{ACT_TICK,       DIR_FWD,   1'b0, '0},
        '{ACT_STOP_MARK,  DIR_FWD,   1'b0, '0},
        '{ACT_RECORD,     DIR_RIGHT, 1'b0, '0},
        '{ACT_BEGIN_PLAY, DIR_FWD,   1'b1, '{DRIVE_FWD,  MODE_PLAY, 7'd4, 1'b0, 1'b0}},
        '{ACT_BEGIN_REC,  DIR_FWD,   1'b0, '0},
        '{ACT_BEGIN_PLAY, DIR_FWD,   1'b0, '0},
        '{ACT_RECORD,     DIR_LEFT,  1'b0, '0},
        '{ACT_TICK,       DIR_FWD,   1'b0, '0}
    };

    function automatic t_dir any_dir();
        return t_dir'($urandom_range(3));
    endfunction

    function automatic void end_replay();
        cur_drive = DRIVE_STOP;
        cur_mode  = MODE_IDLE;
        n_entries = 0;
        play_pos  = 0;
        tick_ctr  = '0;
    endfunction

    function automatic void tick_up();
        if (tick_ctr != TBITS'(TICK_MAX))
            tick_ctr = tick_ctr + 1'b1;
    endfunction

    function automatic t_status step_sequencer(t_action act, t_dir dir);
        t_status s;
        logic    done;
        logic    drop;
        done = 1'b0;
        drop = 1'b0;
        if (cur_mode == MODE_PLAY) begin
            if (act == ACT_TICK) begin
                if (tick_ctr >= path_ticks[play_pos]) begin
                    play_pos++;
                    tick_ctr = '0;
                    if (play_pos >= n_entries) begin
                        end_replay();
                        done = 1'b1;
                    end else begin
                        cur_drive = t_drive'(path_dir[play_pos]);
                    end
                end else begin
                    tick_up();
                end
            end
        end else begin
            case (act)
                ACT_TICK: begin
                    tick_up();
                end
                ACT_BEGIN_REC: begin
                    cur_mode = MODE_REC;
                    tick_ctr = '0;
                end
                ACT_RECORD: begin
                    if (cur_mode == MODE_REC) begin
                        if (n_entries < DEPTH) begin
                            path_dir[n_entries]   = dir;
                            path_ticks[n_entries] = '0;
                            n_entries++;
                            tick_ctr = '0;
                        end else begin
                            drop = 1'b1;
                        end
                    end
                end
                ACT_STOP_MARK: begin
                    if (cur_mode == MODE_REC && n_entries > 0)
                        path_ticks[n_entries-1] = tick_ctr;
                end
                ACT_BEGIN_PLAY: begin
                    if (n_entries == 0) begin
                        end_replay();
                        done = 1'b1;
                    end else begin
                        cur_mode  = MODE_PLAY;
                        play_pos  = 0;
                        tick_ctr  = '0;
                        cur_drive = t_drive'(path_dir[0]);
                    end
                end
                default: begin
                end
            endcase
        end
        s.drive    = cur_drive;
        s.mode_now = cur_mode;
        s.entries  = t_entries'(n_entries);
        s.done     = done;
        s.dropped  = drop;
        return s;
    endfunction

    task automatic send_cmd(t_action act, t_dir dir, bit fixed = 1'b0, t_status want = '0);
        t_status s;
        while ($urandom_range(99) < tx_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid     <= 1'b1;
        cmd_ch.action    <= act;
        cmd_ch.direction <= dir;
        do @(posedge i_clk); while (!cmd_ch.ready);
        s = step_sequencer(act, dir);
        status_q.push_back(fixed ? want : s);
        cmds_sent++;
    endtask

    // hold the command channel idle until every result is back
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge i_clk);
    endtask

    // ticks until the replay in progress ends, with ignored commands mixed in
    task automatic play_out();
        while (cur_mode == MODE_PLAY) begin
            if ($urandom_range(99) < 8)
                send_cmd(t_action'($urandom_range(ACT_BEGIN_REC, ACT_SPARE_7)), any_dir());
            else
                send_cmd(ACT_TICK, any_dir());
        end
    endtask

    task automatic record_session();
        int n_dirs;
        int n_ticks;
        send_cmd(ACT_BEGIN_REC, any_dir());
        n_dirs = ($urandom_range(99) < 15) ? $urandom_range(60, 66) : $urandom_range(1, 8);
        for (int i = 0; i < n_dirs; i++) begin
            send_cmd(ACT_RECORD, any_dir());
            n_ticks = ($urandom_range(9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4);
            repeat (n_ticks) send_cmd(ACT_TICK, any_dir());
            if ($urandom_range(99) < 70)
                send_cmd(ACT_STOP_MARK, any_dir());
            if ($urandom_range(99) < 10) begin
                send_cmd(ACT_TICK, any_dir());
                send_cmd(ACT_STOP_MARK, any_dir());
            end
        end
        // sometimes keep the entries and carry on recording next session
        if ($urandom_range(99) < 85) begin
            send_cmd(ACT_BEGIN_PLAY, any_dir());
            play_out();
        end
    endtask

    task automatic run_random(int n_cmds);
        int stop_at;
        stop_at = cmds_sent + n_cmds;
        while (cmds_sent < stop_at) begin
            if ($urandom_range(99) < 75) begin
                record_session();
            end else begin
                repeat ($urandom_range(1, 6))
                    send_cmd(t_action'($urandom_range(ACT_SPARE_7)), any_dir());
            end
        end
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // result side: random stalls and the comparison of each transaction
    always @(posedge i_clk) begin
        t_status want;
        res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (status_q.size() == 0) begin
                $error("result transaction with nothing expected");
                mismatches++;
            end else begin
                want = status_q.pop_front();
                check_field("drive", want.drive, res_ch.drive);
                check_field("mode_now", want.mode_now, res_ch.mode_now);
                check_field("stored_entries", want.entries, res_ch.stored_entries);
                check_field("replay_done", want.done, res_ch.replay_done);
                check_field("dropped", want.dropped, res_ch.dropped);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        i_rst_n          <= 1'b0;
        cmd_ch.valid     <= 1'b0;
        cmd_ch.action    <= ACT_TICK;
        cmd_ch.direction <= DIR_FWD;
        foreach (path_dir[i]) begin
            path_dir[i]   = DIR_FWD;
            path_ticks[i] = '0;
        end
        end_replay();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tx_idle_pct  = 15;
        rx_stall_pct = 75;
        foreach (directed_rows[i])
            send_cmd(directed_rows[i].action, directed_rows[i].dir,
                     directed_rows[i].fixed, directed_rows[i].want);
        drain();
        run_random(RANDOM_CMDS);
        drain();

        tx_idle_pct  = 75;
        rx_stall_pct = 15;
        run_random(RANDOM_CMDS);
        drain();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        run_random(RANDOM_CMDS);

        drain();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && status_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
rtl/mrrs_pkg.sv
rtl/mrrs_cmd_if.sv
rtl/mrrs_res_if.sv
rtl/mrrs_store.sv
rtl/motion_record_replay_sequencer.sv
tb/tb.sv
